>>> rtl/core/tls_record_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the TLS record deframer checks.
// Both expect i_clk and i_rst_n in scope; checks are off while in reset.
// ----------------------------------------------------------------------------
`ifndef TLS_RECORD_DEFRAMER_ASSERT_SVH
`define TLS_RECORD_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define TRD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define TRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> rtl/core/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the TLS record deframer.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned POS_W        = 17;
    localparam int unsigned FRAG_W       = 16;
    localparam int unsigned LIMIT_W      = 17;
    localparam int unsigned CFG_W        = 17;

    localparam logic [POS_W-1:0] LEN_HIGH_POS = POS_W'(3);
    localparam logic [POS_W-1:0] LEN_LOW_POS  = POS_W'(4);

    localparam logic [FRAG_W-1:0]  MAX_FRAG_RESET  = 16'd16640;
    localparam logic [LIMIT_W-1:0] BUF_LIMIT_RESET = 17'h1FFFF;

    // configuration register indexes
    localparam logic CFG_MAX_FRAG  = 1'b0;
    localparam logic CFG_BUF_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FRAGMENT = 2'd1,
        ERR_LIMIT    = 2'd2
    } t_err;

endpackage

>>> rtl/core/tls_record_deframer.sv
// ----------------------------------------------------------------------------
// tls_record_deframer
// Marks record boundaries in a received TLS byte stream.
// Input channel (i_in_valid / o_in_ready) takes one stream byte per item;
// output channel (o_out_valid / i_out_ready) returns the byte with first,
// header and last flags and the sticky error code (0 none, 1 fragment too
// long, 2 buffer limit exceeded). Fragment length is read from header bytes
// 3 and 4, big-endian.
// An accepted byte is output valid in the cycle after accept; throughput is
// one item per cycle while the receiver is ready. The position counter and
// length compare sit between the input port and the output register.
// While the receiver stalls, the output register holds and a new item is
// taken only in a cycle where the held item leaves. Synchronous reset clears
// position, length and error state and restores the limits (max fragment
// 16640, buffer limit 131071); the error code is cleared only by reset.
// The user must write limits via i_cfg_* only while idle; not enforced.
// ----------------------------------------------------------------------------
module tls_record_deframer import trd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input stream
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    // output stream
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_first_of_record,
    output logic              o_in_header,
    output logic              o_last_of_record,
    output logic [1:0]        o_error_code
);

    logic [FRAG_W-1:0]  r_max_frag;
    logic [LIMIT_W-1:0] r_buf_limit;

    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [7:0]         r_len_hi;
    logic [FRAG_W-1:0]  r_frag,   n_frag;
    t_err               r_err,    n_err;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_first, r_hdr, r_last;

    logic               accept;
    logic               hdr, first, last, at_len_lo;
    logic [POS_W:0]     pos_inc;
    logic [POS_W:0]     rec_len;
    logic [POS_W:0]     limit_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        hdr       = r_pos < POS_W'(HEADER_BYTES);
        first     = r_pos == '0;
        at_len_lo = r_pos == LEN_LOW_POS;
        pos_inc   = {1'b0, r_pos} + (POS_W+1)'(1);
        limit_ext = {1'b0, r_buf_limit};
        n_frag    = at_len_lo ? {r_len_hi, i_data_byte} : r_frag;
        rec_len   = (POS_W+1)'(HEADER_BYTES) + (POS_W+1)'(n_frag);

        // first error wins; header limit check ranks above the length checks
        n_err = r_err;
        if (r_err == ERR_NONE) begin
            priority if (hdr && pos_inc > limit_ext) begin
                n_err = ERR_LIMIT;
            end else if (at_len_lo && n_frag > r_max_frag) begin
                n_err = ERR_FRAGMENT;
            end else if (at_len_lo && rec_len > limit_ext) begin
                n_err = ERR_LIMIT;
            end else begin
                n_err = r_err;
            end
        end

        last  = (r_pos >= LEN_LOW_POS) && (pos_inc >= rec_len);
        n_pos = last ? '0 : pos_inc[POS_W-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frag  <= MAX_FRAG_RESET;
            r_buf_limit <= BUF_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_FRAG:  r_max_frag  <= i_cfg_data[FRAG_W-1:0];
                CFG_BUF_LIMIT: r_buf_limit <= i_cfg_data[LIMIT_W-1:0];
                default:       r_max_frag  <= r_max_frag;
            endcase
        end
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len_hi <= '0;
            r_frag   <= '0;
            r_err    <= ERR_NONE;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_frag <= n_frag;
            r_err  <= n_err;
            if (r_pos == LEN_HIGH_POS) begin
                r_len_hi <= i_data_byte;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_byte <= i_data_byte;
            r_first    <= first;
            r_hdr      <= hdr;
            r_last     <= last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_first_of_record = r_first;
    assign o_in_header       = r_hdr;
    assign o_last_of_record  = r_last;
    assign o_error_code      = r_err;

endmodule

>>> rtl/core/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks on record framing and the sticky error code.
// ----------------------------------------------------------------------------
`include "tls_record_deframer_assert.svh"

module trd_checker import trd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        o_out_byte,
    input  logic              o_first_of_record,
    input  logic              o_in_header,
    input  logic              o_last_of_record,
    input  logic [1:0]        o_error_code
);

    logic       r_expect_first, n_expect_first;
    logic [1:0] r_last_err,     n_last_err;
    logic       out_acc;

    assign out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_expect_first = r_expect_first;
        n_last_err     = r_last_err;
        if (out_acc) begin
            n_expect_first = o_last_of_record;
            n_last_err     = o_error_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_first <= 1'b1;
            r_last_err     <= ERR_NONE;
        end else begin
            r_expect_first <= n_expect_first;
            r_last_err     <= n_last_err;
        end
    end

    // a record starts exactly after the item that closed the previous one
    `TRD_ASSERT_IMPL(a_framing, out_acc, o_first_of_record == r_expect_first)

    `TRD_ASSERT_IMPL(a_first_in_header, o_out_valid && o_first_of_record, o_in_header)

    // once reported, an error code never changes until reset
    `TRD_ASSERT_IMPL(a_sticky_error, o_out_valid && r_last_err != ERR_NONE,
                     o_error_code == r_last_err)

    `TRD_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_out_byte) && $stable(o_error_code))

endmodule

bind tls_record_deframer trd_checker u_trd_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tls_record_deframer. Drives the byte stream with
// bursty valid and a stalling receiver, and predicts framing flags and the
// sticky error code per byte. Tests cover short records, limit extremes,
// random record streams over several limit settings, and the error behaviour.
// ----------------------------------------------------------------------------
module tb;
    import trd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       hdr;
        logic       last;
        t_err       err;
    } t_byte_marks;

    typedef enum int unsigned {RX_FREE, RX_COIN, RX_MOSTLY, RX_PERIODIC} t_rx_mode;
    typedef enum int unsigned {
        FAULT_FRAGMENT, FAULT_LIMIT_HEADER, FAULT_LIMIT_RECORD
    } t_fault;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_idx = CFG_MAX_FRAG;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte = 8'h00;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [7:0]       out_byte;
    logic             first_of_record;
    logic             in_header;
    logic             last_of_record;
    logic [1:0]       error_code;

    tls_record_deframer i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (data_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_out_byte        (out_byte),
        .o_first_of_record (first_of_record),
        .o_in_header       (in_header),
        .o_last_of_record  (last_of_record),
        .o_error_code      (error_code)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb: FAIL");
        $finish;
    end

    // deframer state as the bench sees it
    logic [POS_W-1:0]   rec_pos   = '0;
    logic [7:0]         len_hi    = 8'h00;
    logic [FRAG_W-1:0]  frag_len  = '0;
    t_err               sticky    = ERR_NONE;
    logic [FRAG_W-1:0]  max_frag  = MAX_FRAG_RESET;
    logic [LIMIT_W-1:0] buf_limit = BUF_LIMIT_RESET;

    t_byte_marks pending_marks[$];
    t_byte_marks head_marks;
    int          errors     = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;

    function automatic void raise_error(input t_err code);
        if (sticky == ERR_NONE)
            sticky = code;
    endfunction

    function automatic t_byte_marks mark_byte(input logic [7:0] b);
        t_byte_marks m;
        int unsigned pos;
        pos     = rec_pos;
        m.data  = b;
        m.first = (pos == 0);
        m.hdr   = (pos < HEADER_BYTES);
        m.last  = 1'b0;
        if (m.hdr && pos + 1 > buf_limit)
            raise_error(ERR_LIMIT);
        if (pos == LEN_HIGH_POS) begin
            len_hi = b;
        end else if (pos == LEN_LOW_POS) begin
            frag_len = {len_hi, b};
            if (frag_len > max_frag)
                raise_error(ERR_FRAGMENT);
            else if (HEADER_BYTES + frag_len > buf_limit)
                raise_error(ERR_LIMIT);
        end
        // empty fragment: header byte 4 closes the record
        if (pos >= LEN_LOW_POS && pos + 1 >= HEADER_BYTES + frag_len)
            m.last = 1'b1;
        rec_pos = m.last ? '0 : POS_W'(pos + 1);
        m.err   = sticky;
        return m;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
            errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_marks.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, actual byte %0h", $time,
                         out_byte);
                errors++;
            end else begin
                head_marks = pending_marks.pop_front();
                check_field("out_byte", head_marks.data, out_byte);
                check_field("first_of_record", head_marks.first, first_of_record);
                check_field("in_header", head_marks.hdr, in_header);
                check_field("last_of_record", head_marks.last, last_of_record);
                check_field("error_code", head_marks.err, error_code);
            end
        end
    end

    // receiver back-pressure, switching pattern every so often
    t_rx_mode    rx_mode = RX_FREE;
    int unsigned rx_left = 0;
    logic [3:0]  rx_tick = '0;

    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(RX_FREE, RX_PERIODIC));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
            default:   out_ready <= rx_tick[1];
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        items_sent++;
        pending_marks.push_back(mark_byte(b));
    endtask

    task automatic send_record(input logic [15:0] len);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_FRAG)
            max_frag = value[FRAG_W-1:0];
        else
            buf_limit = value[LIMIT_W-1:0];
    endtask

    // max fragment is 16 bits wide; bit 16 of the write data must be ignored
    task automatic write_max_frag(input int unsigned value);
        write_reg(CFG_MAX_FRAG, {1'($urandom_range(0, 1)), 16'(value)});
    endtask

    task automatic test_directed;
        logic [7:0] seq[$] = '{8'h17, 8'h03, 8'h03, 8'h00, 8'h00,
                               8'h17, 8'h03, 8'h03, 8'h00, 8'h01, 8'hAA,
                               8'hFF, 8'h00, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF};
        foreach (seq[i]) send_byte(seq[i]);
        wait_idle;
    endtask

    task automatic test_limit_extremes;
        write_max_frag(0);
        repeat (3) send_record(16'd0);
        wait_idle;
        write_reg(CFG_BUF_LIMIT, CFG_W'(HEADER_BYTES));
        repeat (2) send_record(16'd0);
        wait_idle;
        write_max_frag(16'hFFFF);
        write_reg(CFG_BUF_LIMIT, CFG_W'(HEADER_BYTES + 7));
        send_record(16'd7);
        send_record(16'd3);
        wait_idle;
        write_reg(CFG_BUF_LIMIT, CFG_W'(BUF_LIMIT_RESET));
        send_record(16'h0100);
        send_record(16'd0);
        wait_idle;
    endtask

    task automatic test_random_records;
        int unsigned cap, mf, bl, len, start;
        start = items_sent;
        for (int p = 0; p < 4; p++) begin
            cap = (p == 3) ? $urandom_range(100, 300) : $urandom_range(0, 60);
            mf  = $urandom_range(0, 1) ? cap : $urandom_range(cap, 65535);
            bl  = $urandom_range(0, 1) ? HEADER_BYTES + cap
                                       : $urandom_range(HEADER_BYTES + cap, 131071);
            write_max_frag(mf);
            write_reg(CFG_BUF_LIMIT, CFG_W'(bl));
            while (items_sent - start < 175 * (p + 1)) begin
                len = ($urandom_range(0, 7) == 0) ? cap : $urandom_range(0, cap);
                send_record(16'(len));
            end
            wait_idle;
        end
    endtask

    // only one error can ever be seen per reset, so the seed picks which one
    task automatic test_sticky_errors;
        t_fault      fault;
        int unsigned len, start;
        fault = t_fault'($urandom_range(FAULT_FRAGMENT, FAULT_LIMIT_RECORD));
        case (fault)
            FAULT_FRAGMENT: begin
                // both checks fail at header byte 4: fragment error must win
                write_max_frag($urandom_range(0, 20));
                len = max_frag + 1 + $urandom_range(0, 5);
                write_reg(CFG_BUF_LIMIT, CFG_W'($urandom_range(HEADER_BYTES,
                                                               HEADER_BYTES - 1 + len)));
                send_record(16'(len));
            end
            FAULT_LIMIT_HEADER: begin
                write_reg(CFG_BUF_LIMIT,
                          $urandom_range(0, 1) ? '0 : CFG_W'($urandom_range(1, 4)));
                send_record(16'($urandom_range(0, 10)));
            end
            default: begin
                write_max_frag(16'hFFFF);
                len = $urandom_range(1, 30);
                write_reg(CFG_BUF_LIMIT, CFG_W'($urandom_range(HEADER_BYTES,
                                                               HEADER_BYTES - 1 + len)));
                send_record(16'(len));
            end
        endcase
        wait_idle;
        // framing carries on; later faults of either kind leave the code alone
        write_max_frag($urandom_range(0, 20));
        write_reg(CFG_BUF_LIMIT, CFG_W'($urandom_range(0, 40)));
        start = items_sent;
        while (items_sent - start < 200)
            send_record(16'($urandom_range(0, 40)));
        wait_idle;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed;
        test_limit_extremes;
        test_random_records;
        test_sticky_errors;
        wait_idle;
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
